### rtl/core/lpe_pkg.sv
// Shared types, widths and constants of the line position estimator.
// No dependencies; used by lpe_ctrl, lpe_dp and line_position_estimator_top.
package lpe_pkg;

    // Sensor array
    localparam int NUM_SENSORS      = 11;
    localparam int SIDE_SENSORS     = 5;    // sensors on each side of center
    localparam int CENTER_IDX       = 5;    // zero-based index of the center sensor
    localparam int ADC_BITS_DEFAULT = 12;

    // Weight magnitudes by zero-based sensor index; left side counts negative
    localparam logic [4:0] WEIGHT_MAG [NUM_SENSORS] = '{
        5'd25, 5'd20, 5'd15, 5'd10, 5'd5, 5'd0, 5'd5, 5'd10, 5'd15, 5'd20, 5'd25
    };

    // Datapath widths
    localparam int THR_W    = 13;           // threshold register
    localparam int MAG_W    = 7;            // one side's weight sum, at most 75
    localparam int CNT_W    = 4;            // on-sensor count, 0..11
    localparam int Q_BITS   = 5;            // quotient magnitude, at most 25
    localparam int STEP_W   = $clog2(Q_BITS);
    localparam int ERR_W    = 6;            // kept error, -25..25
    localparam int OUT_ERR_W = 7;           // reported error, -50..50
    localparam int DIVS_W   = CNT_W + Q_BITS - 1;  // shifted divisor

    localparam logic [THR_W-1:0] THR_RESET = 13'd5000;

    // Configuration map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 1'b0;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DIV    = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic              load;     // capture scan, sum and count
        logic              step;     // one restoring-division step
        logic [STEP_W-1:0] shift;    // quotient bit being resolved
        logic              finish;   // load result and kept error
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic cnt_zero;              // no sensor on in the captured scan
    } status_t;

endpackage

### rtl/core/lpe_ctrl.sv
// Controller of the line position estimator: sequences capture, division and
// result load, and owns both handshakes. Depends on lpe_pkg.
module lpe_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  lpe_pkg::status_t status,
    output lpe_pkg::cmd_t    cmd
);

    lpe_pkg::state_t              state_reg, state_next;
    logic [lpe_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         out_free;

    assign s_ready  = (state_reg == lpe_pkg::ST_IDLE);
    assign m_valid  = out_valid_reg;
    assign out_free = !out_valid_reg || m_ready;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.shift  = step_reg;
        unique case (state_reg)
            lpe_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    step_next  = lpe_pkg::STEP_W'(lpe_pkg::Q_BITS - 1);
                    state_next = lpe_pkg::ST_DIV;
                end
            end
            lpe_pkg::ST_DIV: begin
                if (status.cnt_zero) begin
                    state_next = lpe_pkg::ST_FINISH;
                end else begin
                    cmd.step = 1'b1;
                    if (step_reg == '0) begin
                        state_next = lpe_pkg::ST_FINISH;
                    end else begin
                        step_next = step_reg - 1'b1;
                    end
                end
            end
            lpe_pkg::ST_FINISH: begin
                if (out_free) begin
                    cmd.finish = 1'b1;
                    state_next = lpe_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lpe_pkg::ST_IDLE;
            end
        endcase
    end

    // Output beat valid: set on result load, drop when taken
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.finish) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lpe_pkg::ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/core/lpe_dp.sv
// Datapath of the line position estimator: threshold compare, weighted sums,
// restoring divider, result and kept-error registers. Depends on lpe_pkg.
module lpe_dp #(
    parameter int ADC_BITS = lpe_pkg::ADC_BITS_DEFAULT
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic [lpe_pkg::NUM_SENSORS-1:0][ADC_BITS-1:0] samples,
    input  logic [lpe_pkg::THR_W-1:0]                 threshold,
    input  lpe_pkg::cmd_t                             cmd,
    output lpe_pkg::status_t                          status,
    output logic signed [lpe_pkg::OUT_ERR_W-1:0]      line_error,
    output logic [lpe_pkg::CNT_W-1:0]                 sensors_on
);

    localparam int CMP_W = (ADC_BITS > lpe_pkg::THR_W) ? ADC_BITS : lpe_pkg::THR_W;

    logic [lpe_pkg::NUM_SENSORS-1:0] on_vec;
    logic [lpe_pkg::MAG_W-1:0]       pos_sum, neg_sum, mag_comb;
    logic [lpe_pkg::CNT_W-1:0]       cnt_comb;

    logic [lpe_pkg::MAG_W-1:0]       rem_reg, rem_next;
    logic                            neg_reg;
    logic [lpe_pkg::CNT_W-1:0]       cnt_reg;
    logic [lpe_pkg::Q_BITS-1:0]      quot_reg, quot_next;
    logic [lpe_pkg::DIVS_W-1:0]      div_shift;
    logic                            fits;

    logic signed [lpe_pkg::ERR_W-1:0]     err_comb;
    logic signed [lpe_pkg::ERR_W-1:0]     last_err_reg;
    logic signed [lpe_pkg::OUT_ERR_W-1:0] line_error_reg;
    logic [lpe_pkg::CNT_W-1:0]            sensors_on_reg;

    // Compare each sample with the threshold
    always_comb begin
        for (int i = 0; i < lpe_pkg::NUM_SENSORS; i++) begin
            on_vec[i] = CMP_W'(samples[i]) > CMP_W'(threshold);
        end
    end

    // Sum weight magnitudes per side; the center sensor weighs nothing
    always_comb begin
        neg_sum = '0;
        pos_sum = '0;
        for (int i = 0; i < lpe_pkg::SIDE_SENSORS; i++) begin
            if (on_vec[i]) begin
                neg_sum = neg_sum + lpe_pkg::MAG_W'(lpe_pkg::WEIGHT_MAG[i]);
            end
            if (on_vec[lpe_pkg::CENTER_IDX + 1 + i]) begin
                pos_sum = pos_sum
                        + lpe_pkg::MAG_W'(lpe_pkg::WEIGHT_MAG[lpe_pkg::CENTER_IDX + 1 + i]);
            end
        end
        mag_comb = (pos_sum >= neg_sum) ? (pos_sum - neg_sum) : (neg_sum - pos_sum);
        cnt_comb = lpe_pkg::CNT_W'($countones(on_vec));
    end

    // One restoring-division step: resolve quotient bit cmd.shift
    assign div_shift = lpe_pkg::DIVS_W'(cnt_reg) << cmd.shift;
    assign fits      = lpe_pkg::DIVS_W'(rem_reg) >= div_shift;

    always_comb begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (cmd.load) begin
            rem_next  = mag_comb;
            quot_next = '0;
        end else if (cmd.step) begin
            if (fits) begin
                rem_next = lpe_pkg::MAG_W'(lpe_pkg::DIVS_W'(rem_reg) - div_shift);
            end
            quot_next = {quot_reg[lpe_pkg::Q_BITS-2:0], fits};
        end
    end

    // Apply the sign of the weight sum; truncation toward zero falls out
    assign err_comb = neg_reg ? -$signed({1'b0, quot_reg}) : $signed({1'b0, quot_reg});

    // Scan and division registers
    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        if (cmd.load) begin
            neg_reg <= (neg_sum > pos_sum);
            cnt_reg <= cnt_comb;
        end
    end

    // Result registers
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            sensors_on_reg <= cnt_reg;
            if (cnt_reg == '0) begin
                line_error_reg <= {last_err_reg, 1'b0};
            end else begin
                line_error_reg <= {err_comb[lpe_pkg::ERR_W-1], err_comb};
            end
        end
    end

    // Hold the last error taken with at least one sensor on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_err_reg <= '0;
        end else if (cmd.finish && (cnt_reg != '0)) begin
            last_err_reg <= err_comb;
        end
    end

    assign status.cnt_zero = (cnt_reg == '0);
    assign line_error      = line_error_reg;
    assign sensors_on      = sensors_on_reg;

endmodule

### rtl/core/line_position_estimator_top.sv
// Line position estimator: eleven-sensor weighted centroid with lost-line hold.
// Top level with threshold register and APB port; instantiates lpe_ctrl, lpe_dp.
// Depends on lpe_pkg.
//
// Usage:
//   Input channel (s_*): one beat carries one scan of eleven ADC samples.
//   Result channel (m_*): one beat per scan with the signed line error and
//   the number of sensors above threshold.
//   Configuration: one register, threshold, at byte address 0 (APB write,
//   pready always high). Write it only while no scan is in flight.
// Timing:
//   A scan is captured and summed in its accept cycle, then a restoring
//   divider resolves one quotient bit per cycle, then the result register
//   loads once the output register is free, and m_valid rises with it. A
//   new scan is taken only after that result has loaded. With no sensor on
//   the division steps are skipped.
// Reset: threshold returns to 5000, the kept error to zero, both channels idle.
// Stall: a result waits in the output register while m_ready is low; the
//   next scan is divided meanwhile and its result loads once the first is taken.
module line_position_estimator_top #(
    parameter int ADC_BITS = lpe_pkg::ADC_BITS_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Input channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [ADC_BITS-1:0]                   s_sample_1,
    input  logic [ADC_BITS-1:0]                   s_sample_2,
    input  logic [ADC_BITS-1:0]                   s_sample_3,
    input  logic [ADC_BITS-1:0]                   s_sample_4,
    input  logic [ADC_BITS-1:0]                   s_sample_5,
    input  logic [ADC_BITS-1:0]                   s_sample_6,
    input  logic [ADC_BITS-1:0]                   s_sample_7,
    input  logic [ADC_BITS-1:0]                   s_sample_8,
    input  logic [ADC_BITS-1:0]                   s_sample_9,
    input  logic [ADC_BITS-1:0]                   s_sample_10,
    input  logic [ADC_BITS-1:0]                   s_sample_11,
    // Result channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [lpe_pkg::OUT_ERR_W-1:0]  m_line_error,
    output logic [lpe_pkg::CNT_W-1:0]             m_sensors_on,
    // Configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [lpe_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [lpe_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [lpe_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                  pready
);

    logic [lpe_pkg::THR_W-1:0]                        threshold_reg;
    logic [lpe_pkg::REG_IDX_W-1:0]                    reg_idx;
    logic                                             cfg_write;
    logic [lpe_pkg::NUM_SENSORS-1:0][ADC_BITS-1:0]    samples;
    lpe_pkg::cmd_t                                    cmd;
    lpe_pkg::status_t                                 status;

    // Register access
    assign pready    = 1'b1;
    assign reg_idx   = paddr[lpe_pkg::APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= lpe_pkg::THR_RESET;
        end else if (cfg_write && (reg_idx == lpe_pkg::REG_THRESHOLD)) begin
            threshold_reg <= pwdata[lpe_pkg::THR_W-1:0];
        end
    end

    assign prdata = (reg_idx == lpe_pkg::REG_THRESHOLD)
                  ? lpe_pkg::APB_DATA_W'(threshold_reg) : '0;

    // Gather the scan into one vector, sensor 1 at index 0
    assign samples = {s_sample_11, s_sample_10, s_sample_9, s_sample_8, s_sample_7,
                      s_sample_6, s_sample_5, s_sample_4, s_sample_3, s_sample_2,
                      s_sample_1};

    lpe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lpe_dp #(
        .ADC_BITS (ADC_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .samples    (samples),
        .threshold  (threshold_reg),
        .cmd        (cmd),
        .status     (status),
        .line_error (m_line_error),
        .sensors_on (m_sensors_on)
    );

    // One scan in flight at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("scan accepted while another was in flight");

    // Reported error stays within the doubled weight range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_line_error >= -7'sd50) && (m_line_error <= 7'sd50))
        else $error("line error out of range");

    // With the line seen, the centroid lies within the outer weights
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_sensors_on != '0)) |->
            (m_line_error >= -7'sd25) && (m_line_error <= 7'sd25))
        else $error("centroid outside sensor span");

    // No result beat appears without a scan having entered
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !s_ready || $past(!s_ready))
        else $error("result without a scan");

endmodule

### tb/sv/line_position_checker.sv
// Scoreboard for the line position estimator: predicts the result of every
// accepted scan, tracks threshold writes and checks the result channel.
// Depends on lpe_pkg for widths and the register index.
module line_position_checker #(
    parameter int ADC_W = 12
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         s_valid,
    input  logic                                         s_ready,
    input  logic [lpe_pkg::NUM_SENSORS-1:0][ADC_W-1:0]   scan,
    input  logic                                         m_valid,
    input  logic                                         m_ready,
    input  logic signed [lpe_pkg::OUT_ERR_W-1:0]         m_line_error,
    input  logic [lpe_pkg::CNT_W-1:0]                    m_sensors_on,
    input  logic                                         psel,
    input  logic                                         penable,
    input  logic                                         pwrite,
    input  logic [lpe_pkg::APB_ADDR_W-1:0]               paddr,
    input  logic [lpe_pkg::APB_DATA_W-1:0]               pwdata,
    input  logic [lpe_pkg::APB_DATA_W-1:0]               prdata,
    input  logic                                         pready,
    output int                                           pending_results,
    output int                                           error_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import lpe_pkg::*;

    typedef struct packed {
        logic signed [OUT_ERR_W-1:0] line_error;
        logic [CNT_W-1:0]            sensors_on;
    } position_t;

    localparam int LINE_WEIGHT [NUM_SENSORS] = '{
        -25, -20, -15, -10, -5, 0, 5, 10, 15, 20, 25
    };
    localparam logic [THR_W-1:0] THRESHOLD_AT_RESET = 13'd5000;

    logic [THR_W-1:0]        threshold_q = THRESHOLD_AT_RESET;
    logic signed [ERR_W-1:0] kept_error = '0;
    position_t               expected_positions [$];
    int                      mismatches = 0;
    int                      outstanding = 0;

    assign error_count     = mismatches;
    assign pending_results = outstanding;

    // Weighted centroid of the sensors above threshold; line lost doubles the kept error
    function automatic position_t estimate_position(
        input logic [NUM_SENSORS-1:0][ADC_W-1:0] samples,
        input logic [THR_W-1:0]                  thr,
        input logic signed [ERR_W-1:0]           kept
    );
        int        on_weight_total;
        int        on_count;
        int        err;
        int        i;
        position_t pos;
        on_weight_total = 0;
        on_count        = 0;
        for (i = 0; i < NUM_SENSORS; i++) begin
            if (int'(samples[i]) > int'(thr)) begin
                on_weight_total += LINE_WEIGHT[i];
                on_count++;
            end
        end
        if (on_count > 0) begin
            err = on_weight_total / on_count;
        end else begin
            err = 2 * int'(kept);
        end
        pos.line_error = err[OUT_ERR_W-1:0];
        pos.sensors_on = on_count[CNT_W-1:0];
        return pos;
    endfunction

    always @(posedge aclk) begin
        position_t want;
        if (!aresetn) begin
            threshold_q = THRESHOLD_AT_RESET;
            kept_error  = '0;
            expected_positions.delete();
            outstanding <= 0;
        end else begin
            // Compare each result beat with the oldest prediction
            if (m_valid && m_ready) begin
                if (expected_positions.size() == 0) begin
                    $error("result beat with nothing outstanding: line_error %0d sensors_on %0d",
                           m_line_error, m_sensors_on);
                    mismatches++;
                end else begin
                    want = expected_positions.pop_front();
                    if (m_line_error !== want.line_error) begin
                        $error("line_error: expected %0d, actual %0d",
                               want.line_error, m_line_error);
                        mismatches++;
                    end
                    if (m_sensors_on !== want.sensors_on) begin
                        $error("sensors_on: expected %0d, actual %0d",
                               want.sensors_on, m_sensors_on);
                        mismatches++;
                    end
                end
            end

            // Predict each accepted scan and advance the kept error
            if (s_valid && s_ready) begin
                want = estimate_position(scan, threshold_q, kept_error);
                if (want.sensors_on != 0) begin
                    kept_error = want.line_error[ERR_W-1:0];
                end
                expected_positions.push_back(want);
            end

            // Track threshold writes and check read-back; other indexes are ignored
            if (psel && penable && pready && (paddr >> 2) == REG_THRESHOLD) begin
                if (pwrite) begin
                    threshold_q = pwdata[THR_W-1:0];
                end else if (prdata !== APB_DATA_W'(threshold_q)) begin
                    $error("prdata: expected %0d, actual %0d", threshold_q, prdata);
                    mismatches++;
                end
            end

            outstanding <= expected_positions.size();
        end
    end

endmodule

### tb/sv/line_position_estimator_top_test.sv
// Testbench top for the line position estimator: clock, reset, scan and
// threshold stimulus, result-side backpressure and the verdict.
// Depends on lpe_pkg, line_position_estimator_top and line_position_checker.
module line_position_estimator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lpe_pkg::*;

    localparam int ADC_W         = ADC_BITS_DEFAULT;
    localparam int ADC_MAX       = (1 << ADC_W) - 1;
    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 400;
    localparam int CHUNK_SCANS   = 258;
    localparam int CYCLE_LIMIT   = 200000;

    localparam logic [APB_ADDR_W-1:0] THRESHOLD_ADDR = APB_ADDR_W'(REG_THRESHOLD) << 2;
    localparam logic [APB_ADDR_W-1:0] UNMAPPED_ADDR  = APB_ADDR_W'(1) << 2;

    localparam logic [NUM_SENSORS-1:0] NONE_ON = '0;
    localparam logic [NUM_SENSORS-1:0] ALL_ON  = '1;

    typedef logic [NUM_SENSORS-1:0][ADC_W-1:0] scan_t;

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    scan_t                         scan_bus;
    logic                          m_valid;
    logic                          m_ready;
    logic signed [OUT_ERR_W-1:0]   m_line_error;
    logic [CNT_W-1:0]              m_sensors_on;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [APB_ADDR_W-1:0]         paddr;
    logic [APB_DATA_W-1:0]         pwdata;
    logic [APB_DATA_W-1:0]         prdata;
    logic                          pready;

    int pending_results;
    int error_count;
    int src_idle_pct     = 0;
    int sink_idle_pct    = 0;
    int cycle_count      = 0;
    bit hold_off_request = 1'b0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    line_position_estimator_top #(
        .ADC_BITS (ADC_W)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_1   (scan_bus[0]),
        .s_sample_2   (scan_bus[1]),
        .s_sample_3   (scan_bus[2]),
        .s_sample_4   (scan_bus[3]),
        .s_sample_5   (scan_bus[4]),
        .s_sample_6   (scan_bus[5]),
        .s_sample_7   (scan_bus[6]),
        .s_sample_8   (scan_bus[7]),
        .s_sample_9   (scan_bus[8]),
        .s_sample_10  (scan_bus[9]),
        .s_sample_11  (scan_bus[10]),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_line_error (m_line_error),
        .m_sensors_on (m_sensors_on),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    line_position_checker #(
        .ADC_W (ADC_W)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .scan            (scan_bus),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_line_error    (m_line_error),
        .m_sensors_on    (m_sensors_on),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .pending_results (pending_results),
        .error_count     (error_count)
    );

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result-side backpressure, with one long hold-off on request
    initial begin
        int hold_left;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                m_ready <= 1'b0;
                hold_left = HOLD_CYCLES;
                while (hold_left > 0) begin
                    @(posedge aclk);
                    hold_left--;
                end
            end
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Sensors in the mask well above the line level, the rest at zero
    function automatic scan_t rail_scan(input logic [NUM_SENSORS-1:0] mask);
        scan_t s;
        int    i;
        for (i = 0; i < NUM_SENSORS; i++) begin
            s[i] = mask[i] ? ADC_W'(ADC_MAX) : '0;
        end
        return s;
    endfunction

    // Random levels: above threshold for sensors in the mask, at or below for the rest
    function automatic scan_t scan_from_mask(input logic [NUM_SENSORS-1:0] mask,
                                             input int thr);
        scan_t s;
        int    i;
        for (i = 0; i < NUM_SENSORS; i++) begin
            if (mask[i] && thr < ADC_MAX) begin
                s[i] = ADC_W'($urandom_range(ADC_MAX, thr + 1));
            end else if (mask[i]) begin
                s[i] = ADC_W'(ADC_MAX);
            end else begin
                s[i] = ADC_W'($urandom_range(thr < ADC_MAX ? thr : ADC_MAX, 0));
            end
        end
        return s;
    endfunction

    // Most often a narrow band of adjacent sensors, plus raw noise, scattered masks and lost line
    function automatic scan_t random_scan(input int thr);
        scan_t                   s;
        logic [NUM_SENSORS-1:0]  mask;
        int                      pick;
        int                      center;
        int                      width;
        int                      i;
        pick = $urandom_range(99);
        mask = NONE_ON;
        if (pick < 25) begin
            for (i = 0; i < NUM_SENSORS; i++) begin
                s[i] = ADC_W'($urandom_range(ADC_MAX, 0));
            end
            return s;
        end else if (pick < 70) begin
            center = $urandom_range(NUM_SENSORS - 1, 0);
            width  = $urandom_range(4, 1);
            for (i = 0; i < NUM_SENSORS; i++) begin
                mask[i] = (i >= center) && (i < center + width);
            end
        end else if (pick < 88) begin
            mask = NUM_SENSORS'($urandom());
        end
        return scan_from_mask(mask, thr);
    endfunction

    // Offer one scan and hold it until accepted
    task automatic offer_scan(input scan_t samples);
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_valid  <= 1'b1;
        scan_bus <= samples;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and wait until every result is out and the block is quiet
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_access(input logic write_en, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write_en;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Program a threshold with random upper bits, then read it back
    task automatic set_threshold(input int thr);
        apb_access(1'b1, THRESHOLD_ADDR, ($urandom() & 32'hFFFF_E000) | APB_DATA_W'(thr));
        apb_access(1'b0, THRESHOLD_ADDR, '0);
    endtask

    task automatic run_chunk(input int thr, input int src_pct, input int sink_pct,
                             input bit with_hold_off);
        wait_drained();
        set_threshold(thr);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        hold_off_request = with_hold_off;
        repeat (CHUNK_SCANS) offer_scan(random_scan(thr));
    endtask

    initial begin
        scan_t edge_scan;
        int    i;
        aresetn  = 1'b0;
        s_valid  = 1'b0;
        scan_bus = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Threshold at reset is above the sample range: nothing counts as on
        offer_scan(rail_scan(ALL_ON));
        wait_drained();
        apb_access(1'b0, THRESHOLD_ADDR, '0);
        apb_access(1'b1, UNMAPPED_ADDR, 32'd100);
        apb_access(1'b0, THRESHOLD_ADDR, '0);
        apb_access(1'b1, THRESHOLD_ADDR, 32'd2047);

        // Every weight alone, then lose the line on each side
        for (i = 0; i < NUM_SENSORS; i++) begin
            offer_scan(rail_scan(NUM_SENSORS'(1) << i));
        end
        offer_scan(rail_scan(NONE_ON));
        offer_scan(rail_scan(NUM_SENSORS'(1)));
        offer_scan(rail_scan(NONE_ON));
        offer_scan(rail_scan(ALL_ON));
        // Uneven pairs exercise truncation toward zero on both signs
        offer_scan(rail_scan(11'b000_0000_0011));
        offer_scan(rail_scan(11'b110_0000_0000));
        offer_scan(rail_scan(11'b000_0010_0001));
        // Samples at and just above the threshold
        for (i = 0; i < NUM_SENSORS; i++) begin
            edge_scan[i] = (i % 2 == 0) ? 12'd2047 : 12'd2048;
        end
        offer_scan(edge_scan);

        // Lowest threshold: zero is off, one is on
        wait_drained();
        apb_access(1'b1, THRESHOLD_ADDR, '0);
        offer_scan(rail_scan(NONE_ON));
        offer_scan('{default: 12'd1});

        // Highest threshold, written with every upper bit set
        wait_drained();
        apb_access(1'b1, THRESHOLD_ADDR, '1);
        apb_access(1'b0, THRESHOLD_ADDR, '0);
        offer_scan(rail_scan(ALL_ON));

        // Random scans: sender rarely idles, receiver often stalls; then swapped; then neither idles
        run_chunk($urandom_range(ADC_MAX - 1, 1), 7, 50, 1'b0);
        run_chunk(0, 7, 50, 1'b0);
        run_chunk($urandom_range(ADC_MAX - 1, 1), 50, 7, 1'b0);
        run_chunk(ADC_MAX - 1, 50, 7, 1'b0);
        run_chunk($urandom_range(ADC_MAX - 1, 1), 0, 0, 1'b1);
        run_chunk($urandom_range(ADC_MAX - 1, 1), 0, 0, 1'b0);

        wait_drained();
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### line_position_estimator_top.f
rtl/core/lpe_pkg.sv
rtl/core/lpe_ctrl.sv
rtl/core/lpe_dp.sv
rtl/core/line_position_estimator_top.sv
tb/sv/line_position_checker.sv
tb/sv/line_position_estimator_top_test.sv
